// ===== hw/rtl/lspc_pkg.sv =====
package lspc_pkg;

    localparam int PAGE_COUNT_DEF          = 32;
    localparam int PAGE_SHIFT_DEF          = 2;
    localparam int MAX_REQUEST_SECTORS_DEF = 64;

    localparam int SECTOR_W    = 32;
    localparam int COUNT_W     = 7;
    localparam int BOFF_W      = 6;
    localparam int SLOT_W      = 5;
    localparam int POFF_W      = 2;
    localparam int MAX_RESULTS = 64;

    typedef enum logic [1:0] {
        ACT_READ  = 2'd0,
        ACT_WRITE = 2'd1,
        ACT_INVAL = 2'd2,
        ACT_BAD   = 2'd3
    } action_t;

    typedef enum logic [2:0] {
        CMD_COPY   = 3'd0,
        CMD_WTHRU  = 3'd1,
        CMD_FILL   = 3'd2,
        CMD_DREAD  = 3'd3,
        CMD_DWRITE = 3'd4,
        CMD_DONE   = 3'd5,
        CMD_REJECT = 3'd6
    } cmd_t;

    typedef enum logic [3:0] {
        ST_IDLE, ST_DECODE, ST_DIRECT, ST_FINISH, ST_TOP, ST_SRCH_RD, ST_SRCH_CHK,
        ST_DECIDE, ST_EVICT_RD, ST_EVICT_CHK, ST_FILL, ST_PR_RD, ST_PR_W1, ST_PR_W2,
        ST_PR_W3
    } state_t;

    typedef enum logic [3:0] {
        OP_IDLE, OP_DECODE, OP_DIRECT, OP_FINISH, OP_TOP, OP_SRCH_RD, OP_SRCH_CHK,
        OP_DECIDE, OP_EVICT_RD, OP_EVICT_CHK, OP_FILL, OP_PR_RD, OP_PR_W1, OP_PR_W2,
        OP_PR_W3
    } op_t;

    typedef struct packed {
        op_t  op;
        logic in_ready;
    } lspc_ctrl_t;

    typedef struct packed {
        logic out_free;
        logic dec_fin;
        logic dec_direct;
        logic num_zero;
        logic need_search;
        logic walk_go;
        logic srch_stop;
        logic dec_fill;
        logic need_promote;
        logic evict_stop;
        logic fill_pr;
    } lspc_status_t;

endpackage

// ===== hw/rtl/lspc_ctrl.sv =====
module lspc_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    input  lspc_pkg::lspc_status_t st,
    output lspc_pkg::lspc_ctrl_t   ctrl
);
    import lspc_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:      if (s_tvalid) state_next = ST_DECODE;
            ST_DECODE: begin
                if (st.dec_fin)         state_next = ST_FINISH;
                else if (st.dec_direct) state_next = ST_DIRECT;
                else                    state_next = ST_TOP;
            end
            ST_DIRECT:    if (st.out_free) state_next = ST_FINISH;
            ST_FINISH:    if (st.out_free) state_next = ST_IDLE;
            ST_TOP: begin
                if (st.num_zero)         state_next = ST_FINISH;
                else if (st.need_search) state_next = ST_SRCH_RD;
                else                     state_next = ST_DECIDE;
            end
            ST_SRCH_RD:   state_next = st.walk_go ? ST_SRCH_CHK : ST_DECIDE;
            ST_SRCH_CHK:  state_next = st.srch_stop ? ST_DECIDE : ST_SRCH_RD;
            ST_DECIDE: begin
                if (st.dec_fill)      state_next = ST_EVICT_RD;
                else if (st.out_free) state_next = st.need_promote ? ST_PR_RD : ST_TOP;
            end
            ST_EVICT_RD:  state_next = st.walk_go ? ST_EVICT_CHK : ST_FILL;
            ST_EVICT_CHK: state_next = st.evict_stop ? ST_FILL : ST_EVICT_RD;
            ST_FILL:      if (st.out_free) state_next = st.fill_pr ? ST_PR_RD : ST_TOP;
            ST_PR_RD:     state_next = ST_PR_W1;
            ST_PR_W1:     state_next = ST_PR_W2;
            ST_PR_W2:     state_next = ST_PR_W3;
            ST_PR_W3:     state_next = ST_TOP;
            default:      state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        ctrl.in_ready = 1'b0;
        ctrl.op       = OP_IDLE;
        unique case (state_reg)
            ST_IDLE: begin
                ctrl.op       = OP_IDLE;
                ctrl.in_ready = 1'b1;
            end
            ST_DECODE:    ctrl.op = OP_DECODE;
            ST_DIRECT:    ctrl.op = OP_DIRECT;
            ST_FINISH:    ctrl.op = OP_FINISH;
            ST_TOP:       ctrl.op = OP_TOP;
            ST_SRCH_RD:   ctrl.op = OP_SRCH_RD;
            ST_SRCH_CHK:  ctrl.op = OP_SRCH_CHK;
            ST_DECIDE:    ctrl.op = OP_DECIDE;
            ST_EVICT_RD:  ctrl.op = OP_EVICT_RD;
            ST_EVICT_CHK: ctrl.op = OP_EVICT_CHK;
            ST_FILL:      ctrl.op = OP_FILL;
            ST_PR_RD:     ctrl.op = OP_PR_RD;
            ST_PR_W1:     ctrl.op = OP_PR_W1;
            ST_PR_W2:     ctrl.op = OP_PR_W2;
            ST_PR_W3:     ctrl.op = OP_PR_W3;
            default:      ctrl.op = OP_IDLE;
        endcase
    end

`ifndef SYNTHESIS
    a_ready_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl.in_ready |-> state_reg == ST_IDLE)
        else $error("input ready outside idle");
    a_accept_decode: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE && s_tvalid) |=> state_reg == ST_DECODE)
        else $error("accepted beat not decoded");
    a_promote_seq: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_PR_W1 |=> state_reg == ST_PR_W2 ##1 state_reg == ST_PR_W3)
        else $error("promote sequence broken");
`endif

endmodule

// ===== hw/rtl/lspc_dp.sv =====
module lspc_dp #(
    parameter int PAGE_COUNT          = lspc_pkg::PAGE_COUNT_DEF,
    parameter int PAGE_SHIFT          = lspc_pkg::PAGE_SHIFT_DEF,
    parameter int MAX_REQUEST_SECTORS = lspc_pkg::MAX_REQUEST_SECTORS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  lspc_pkg::lspc_ctrl_t   ctrl,
    output lspc_pkg::lspc_status_t st,
    input  logic                  s_tvalid,
    input  logic [47:0]           s_tdata,
    input  logic [1:0]            s_tuser,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [55:0]           m_tdata,
    output logic [2:0]            m_tuser,
    output logic                  m_tlast,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic                  cfg_data
);
    import lspc_pkg::*;

    localparam int IW = (PAGE_COUNT > 1) ? $clog2(PAGE_COUNT) : 1;
    localparam int LW = $clog2(PAGE_COUNT + 1);
    localparam int TW = SECTOR_W - PAGE_SHIFT;
    localparam int PS = 1 << PAGE_SHIFT;
    localparam logic [LW-1:0] NONE = LW'(PAGE_COUNT);
    localparam logic [SECTOR_W-1:0] PMASK = SECTOR_W'(PS - 1);
    localparam logic [BOFF_W-1:0] CNT_FULL = BOFF_W'(MAX_RESULTS - 1);

    // request registers
    action_t             action_reg;
    logic [3:0]          drive_reg;
    logic [SECTOR_W-1:0] sec_reg;
    logic [COUNT_W-1:0]  num_reg;
    logic                aligned_reg;
    logic                partial_reg;
    cmd_t                fin_reg;
    logic [BOFF_W-1:0]   boff_reg;
    logic [BOFF_W-1:0]   cnt_reg;

    // cache state
    logic [PAGE_COUNT-1:0] valid_reg;
    logic [PAGE_COUNT-1:0] omod_reg;
    logic [PAGE_COUNT-1:0] nmod_reg;
    logic [LW-1:0]         newest_reg;
    logic [LW-1:0]         oldest_reg;
    logic [3:0]            owner_reg;
    logic                  cache_ready_reg;
    logic                  enable_reg;

    // walk and lookup
    logic [LW-1:0]       ptr_reg;
    logic [LW-1:0]       steps_reg;
    logic [LW-1:0]       best_reg;
    logic [TW-1:0]       best_tag_reg;
    logic [LW-1:0]       p_reg;
    logic [TW-1:0]       p_tag_reg;
    logic [SECTOR_W:0]   sbase_reg;
    logic                sbase_none_reg;

    // memories
    logic [TW-1:0] tag_mem [PAGE_COUNT];
    logic [LW-1:0] old_mem [PAGE_COUNT];
    logic [LW-1:0] new_mem [PAGE_COUNT];
    logic [TW-1:0] tag_q;
    logic [LW-1:0] old_q, new_q;
    logic          omod_q, nmod_q;
    logic [IW-1:0] raddr_q;

    logic [IW-1:0] rd_addr;
    logic          tag_we, old_we, new_we;
    logic [IW-1:0] tag_wa, old_wa, new_wa;
    logic [LW-1:0] old_wd, new_wd;

    // output register
    logic                m_tvalid_reg;
    cmd_t                o_cmd_reg;
    logic [SLOT_W-1:0]   o_slot_reg;
    logic [POFF_W-1:0]   o_poff_reg;
    logic [SECTOR_W-1:0] o_sec_reg;
    logic [COUNT_W-1:0]  o_cnt_reg;
    logic [BOFF_W-1:0]   o_boff_reg;
    logic                o_last_reg;

    logic                out_load;
    cmd_t                n_cmd;
    logic [SLOT_W-1:0]   n_slot;
    logic [POFF_W-1:0]   n_poff;
    logic [SECTOR_W-1:0] n_sec;
    logic [COUNT_W-1:0]  n_cnt;
    logic [BOFF_W-1:0]   n_boff;
    logic                n_last;

    // combinational helpers
    logic                out_free, wr, room;
    logic [SECTOR_W-1:0] poff32, pbase;
    logic [TW-1:0]       tag;
    logic [COUNT_W-1:0]  pg_rem, cur_pg, cur_lim, cur_sel;
    logic [SECTOR_W-1:0] p_base_sec, lim;
    logic                hit, over, need_clear, is_fill;
    logic                ptr_vld, nw_vld;
    logic [LW-1:0]       old_eff, new_eff;

    assign out_free = !m_tvalid_reg || m_tready;
    assign wr       = (action_reg == ACT_WRITE);
    assign room     = (cnt_reg != CNT_FULL);
    assign poff32   = sec_reg & PMASK;
    assign pbase    = sec_reg & ~PMASK;
    assign tag      = TW'(sec_reg >> PAGE_SHIFT);
    assign pg_rem   = COUNT_W'(PS) - COUNT_W'(poff32);
    assign cur_pg   = (num_reg < pg_rem) ? num_reg : pg_rem;
    assign hit      = (p_reg != NONE) && (p_tag_reg == tag);
    assign is_fill  = !hit && !wr && (partial_reg || !aligned_reg);
    assign p_base_sec = SECTOR_W'(p_tag_reg) << PAGE_SHIFT;
    assign lim      = p_base_sec - sec_reg;
    assign cur_lim  = ((p_reg != NONE) && (p_base_sec >= sec_reg)
                       && (lim < SECTOR_W'(num_reg))) ? COUNT_W'(lim) : num_reg;
    assign cur_sel  = hit ? cur_pg : cur_lim;
    assign over     = (num_reg > COUNT_W'(MAX_REQUEST_SECTORS))
                   || (({1'b0, sec_reg} + (SECTOR_W+1)'(num_reg))
                       > {1'b1, {SECTOR_W{1'b0}}});
    assign need_clear = !cache_ready_reg || (drive_reg != owner_reg);
    assign ptr_vld  = (ptr_reg < NONE) && valid_reg[ptr_reg[IW-1:0]];
    assign old_eff  = omod_q ? old_q : LW'(raddr_q) + LW'(1);
    assign new_eff  = nmod_q ? new_q : ((raddr_q == '0) ? NONE : LW'(raddr_q) - LW'(1));
    assign nw_vld   = (new_eff < NONE) && valid_reg[new_eff[IW-1:0]];

    always_comb begin
        st.out_free     = out_free;
        st.dec_fin      = (action_reg == ACT_BAD) || (action_reg == ACT_INVAL)
                       || (num_reg == '0) || over;
        st.dec_direct   = !enable_reg;
        st.num_zero     = (num_reg == '0);
        st.need_search  = !sbase_none_reg && ({1'b0, pbase} >= sbase_reg);
        st.walk_go      = (steps_reg < NONE) && (ptr_reg < NONE);
        st.srch_stop    = !ptr_vld || (tag_q == tag);
        st.dec_fill     = is_fill;
        st.need_promote = hit && !((poff32 == '0) && (cur_pg == COUNT_W'(PS)))
                       && (p_reg != newest_reg);
        st.evict_stop   = ptr_vld || (new_eff == NONE) || nw_vld;
        st.fill_pr      = (ptr_reg != newest_reg);
    end

    // memory ports
    always_comb begin
        rd_addr = ptr_reg[IW-1:0];
        tag_we  = 1'b0;
        tag_wa  = ptr_reg[IW-1:0];
        old_we  = 1'b0;
        old_wa  = '0;
        old_wd  = '0;
        new_we  = 1'b0;
        new_wa  = '0;
        new_wd  = '0;
        unique case (ctrl.op)
            OP_PR_RD: rd_addr = p_reg[IW-1:0];
            OP_FILL:  tag_we  = out_free;
            OP_PR_W1: begin
                old_we = (new_eff != NONE);
                old_wa = new_eff[IW-1:0];
                old_wd = old_eff;
                new_we = (old_eff != NONE);
                new_wa = old_eff[IW-1:0];
                new_wd = new_eff;
            end
            OP_PR_W2: begin
                old_we = 1'b1;
                old_wa = p_reg[IW-1:0];
                old_wd = newest_reg;
                new_we = 1'b1;
                new_wa = newest_reg[IW-1:0];
                new_wd = p_reg;
            end
            OP_PR_W3: begin
                new_we = 1'b1;
                new_wa = p_reg[IW-1:0];
                new_wd = NONE;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (tag_we) tag_mem[tag_wa] <= tag;
        if (old_we) old_mem[old_wa] <= old_wd;
        if (new_we) new_mem[new_wa] <= new_wd;
        tag_q   <= tag_mem[rd_addr];
        old_q   <= old_mem[rd_addr];
        new_q   <= new_mem[rd_addr];
        omod_q  <= omod_reg[rd_addr];
        nmod_q  <= nmod_reg[rd_addr];
        raddr_q <= rd_addr;
    end

    // result builder
    always_comb begin
        out_load = 1'b0;
        n_cmd    = CMD_DONE;
        n_slot   = '0;
        n_poff   = '0;
        n_sec    = '0;
        n_cnt    = '0;
        n_boff   = '0;
        n_last   = 1'b0;
        unique case (ctrl.op)
            OP_DIRECT: begin
                out_load = out_free && room;
                n_cmd    = wr ? CMD_DWRITE : CMD_DREAD;
                n_sec    = sec_reg;
                n_cnt    = num_reg;
            end
            OP_FINISH: begin
                out_load = out_free;
                n_cmd    = fin_reg;
                n_last   = 1'b1;
            end
            OP_DECIDE: begin
                out_load = !is_fill && out_free && room;
                n_sec    = sec_reg;
                n_cnt    = cur_sel;
                n_boff   = boff_reg;
                if (hit) begin
                    n_cmd  = wr ? CMD_WTHRU : CMD_COPY;
                    n_slot = SLOT_W'(p_reg);
                    n_poff = POFF_W'(poff32);
                end else begin
                    n_cmd  = wr ? CMD_DWRITE : CMD_DREAD;
                end
            end
            OP_FILL: begin
                out_load = out_free && room;
                n_cmd    = CMD_FILL;
                n_slot   = SLOT_W'(ptr_reg);
                n_sec    = pbase;
                n_cnt    = COUNT_W'(PS);
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            o_cmd_reg  <= n_cmd;
            o_slot_reg <= n_slot;
            o_poff_reg <= n_poff;
            o_sec_reg  <= n_sec;
            o_cnt_reg  <= n_cnt;
            o_boff_reg <= n_boff;
            o_last_reg <= n_last;
        end
    end

    // request and walk registers
    always_ff @(posedge aclk) begin
        unique case (ctrl.op)
            OP_IDLE: begin
                if (s_tvalid) begin
                    action_reg  <= action_t'(s_tuser);
                    drive_reg   <= s_tdata[3:0];
                    sec_reg     <= s_tdata[35:4];
                    num_reg     <= s_tdata[42:36];
                    aligned_reg <= s_tdata[43];
                end
            end
            OP_DECODE: begin
                cnt_reg        <= '0;
                boff_reg       <= '0;
                sbase_reg      <= '0;
                sbase_none_reg <= 1'b0;
                p_reg          <= NONE;
                partial_reg    <= (num_reg < COUNT_W'(PS));
                fin_reg        <= ((action_reg == ACT_BAD)
                                   || ((action_reg != ACT_INVAL) && (num_reg != '0) && over))
                                  ? CMD_REJECT : CMD_DONE;
            end
            OP_DIRECT: if (out_load) cnt_reg <= cnt_reg + BOFF_W'(1);
            OP_TOP: begin
                ptr_reg      <= newest_reg;
                steps_reg    <= '0;
                best_reg     <= NONE;
                best_tag_reg <= '0;
            end
            OP_SRCH_RD: begin
                if (!st.walk_go) begin
                    p_reg          <= best_reg;
                    p_tag_reg      <= best_tag_reg;
                    sbase_reg      <= (SECTOR_W+1)'(best_tag_reg) * (SECTOR_W+1)'(PS)
                                      + (SECTOR_W+1)'(1);
                    sbase_none_reg <= (best_reg == NONE);
                end
            end
            OP_SRCH_CHK: begin
                if (!ptr_vld) begin
                    p_reg          <= best_reg;
                    p_tag_reg      <= best_tag_reg;
                    sbase_reg      <= (SECTOR_W+1)'(best_tag_reg) * (SECTOR_W+1)'(PS)
                                      + (SECTOR_W+1)'(1);
                    sbase_none_reg <= (best_reg == NONE);
                end else if (tag_q == tag) begin
                    p_reg          <= ptr_reg;
                    p_tag_reg      <= tag;
                    sbase_reg      <= {1'b0, pbase} + (SECTOR_W+1)'(1);
                    sbase_none_reg <= 1'b0;
                end else begin
                    if (tag_q > tag && (best_reg == NONE || tag_q < best_tag_reg)) begin
                        best_reg     <= ptr_reg;
                        best_tag_reg <= tag_q;
                    end
                    ptr_reg   <= old_eff;
                    steps_reg <= steps_reg + LW'(1);
                end
            end
            OP_DECIDE: begin
                if (is_fill) begin
                    ptr_reg   <= oldest_reg;
                    steps_reg <= '0;
                end else if (out_free) begin
                    sec_reg  <= sec_reg + SECTOR_W'(cur_sel);
                    num_reg  <= num_reg - cur_sel;
                    boff_reg <= boff_reg + BOFF_W'(cur_sel);
                    if (out_load) cnt_reg <= cnt_reg + BOFF_W'(1);
                end
            end
            OP_EVICT_CHK: begin
                if (!st.evict_stop) begin
                    ptr_reg   <= new_eff;
                    steps_reg <= steps_reg + LW'(1);
                end
            end
            OP_FILL: begin
                if (out_free) begin
                    p_reg          <= ptr_reg;
                    p_tag_reg      <= tag;
                    sbase_reg      <= {1'b0, pbase} + (SECTOR_W+1)'(1);
                    sbase_none_reg <= 1'b0;
                    if (out_load) cnt_reg <= cnt_reg + BOFF_W'(1);
                end
            end
            default: ;
        endcase
    end

    // control state with reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg    <= 1'b0;
            valid_reg       <= '0;
            omod_reg        <= '0;
            nmod_reg        <= '0;
            newest_reg      <= '0;
            oldest_reg      <= LW'(PAGE_COUNT - 1);
            owner_reg       <= '0;
            cache_ready_reg <= 1'b0;
            enable_reg      <= 1'b1;
        end else begin
            if (out_load)      m_tvalid_reg <= 1'b1;
            else if (m_tready) m_tvalid_reg <= 1'b0;

            if (cfg_valid) begin
                enable_reg      <= cfg_data;
                cache_ready_reg <= 1'b0;
            end

            if (old_we) omod_reg[old_wa] <= 1'b1;
            if (new_we) nmod_reg[new_wa] <= 1'b1;

            unique case (ctrl.op)
                OP_DECODE: begin
                    // invalidate, or a cached request that finds the cache stale
                    if ((action_reg == ACT_INVAL)
                        || ((action_reg != ACT_BAD) && (num_reg != '0) && !over
                            && enable_reg && need_clear)) begin
                        valid_reg       <= '0;
                        omod_reg        <= '0;
                        nmod_reg        <= '0;
                        newest_reg      <= '0;
                        oldest_reg      <= LW'(PAGE_COUNT - 1);
                        cache_ready_reg <= 1'b1;
                        if (action_reg != ACT_INVAL) owner_reg <= drive_reg;
                    end
                end
                OP_FILL:  if (out_free) valid_reg[ptr_reg[IW-1:0]] <= 1'b1;
                OP_PR_W1: if (old_eff == NONE) oldest_reg <= new_eff;
                OP_PR_W3: newest_reg <= p_reg;
                default: ;
            endcase
        end
    end

    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tuser   = o_cmd_reg;
    assign m_tlast   = o_last_reg;
    assign m_tdata   = {4'b0, o_boff_reg, o_cnt_reg, o_sec_reg, o_poff_reg, o_slot_reg};

`ifndef SYNTHESIS
    a_newest_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (newest_reg < NONE) && (oldest_reg < NONE))
        else $error("recency end pointer out of range");
    a_inval_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (ctrl.op == OP_DECODE && action_reg == ACT_INVAL) |=> valid_reg == '0)
        else $error("invalidate left valid pages");
    a_last_is_final: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tlast) |-> (m_tuser == CMD_DONE || m_tuser == CMD_REJECT))
        else $error("last beat is not done or rejected");
    a_fill_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        (ctrl.op == OP_FILL && out_free) |=> valid_reg[$past(ptr_reg[IW-1:0])])
        else $error("filled slot not marked valid");
`endif

endmodule

// ===== hw/rtl/lru_sector_page_cache_control.sv =====
// Tag and LRU engine of a write-through sector cache, one request at a time.
// A request beat is taken in idle and decoded; a done or rejected beat is loaded in the finish
// state, and the next request is taken only once that beat is in the output register. A cached
// request issues each command from the decide or fill state, after a recency walk of up to
// PAGE_COUNT entries on each page lookup or eviction, and a promotion after some hits and fills.
// Reset (aresetn low, synchronous): all pages empty, recency order restored at once,
// cache enabled, first cached request clears the cache.
module lru_sector_page_cache_control #(
    parameter int PAGE_COUNT          = lspc_pkg::PAGE_COUNT_DEF,
    parameter int PAGE_SHIFT          = lspc_pkg::PAGE_SHIFT_DEF,
    parameter int MAX_REQUEST_SECTORS = lspc_pkg::MAX_REQUEST_SECTORS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    // request beats
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,  // drive[3:0], start_sector[35:4], request_sectors[42:36],
                                  // buffer_aligned[43]
    input  logic [1:0]  s_tuser,  // action[1:0]
    // command beats
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,  // slot[4:0], page_offset[6:5], device_sector[38:7],
                                  // sector_count[45:39], buffer_offset[51:46]
    output logic [2:0]  m_tuser,  // command[2:0]
    output logic        m_tlast,  // last
    // cache_enable register
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_data
);
    import lspc_pkg::*;

    lspc_ctrl_t   ctrl;
    lspc_status_t st;

    // sequence the request: decode, lookup walk, evict walk, fill, promote
    lspc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .st       (st),
        .ctrl     (ctrl)
    );

    assign s_tready = ctrl.in_ready;

    // hold tags, links and the command output register
    lspc_dp #(
        .PAGE_COUNT          (PAGE_COUNT),
        .PAGE_SHIFT          (PAGE_SHIFT),
        .MAX_REQUEST_SECTORS (MAX_REQUEST_SECTORS)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctrl      (ctrl),
        .st        (st),
        .s_tvalid  (s_tvalid),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

endmodule

// ===== tb/tb_lru_sector_page_cache_control.sv =====
`timescale 1ns / 1ps

module tb_lru_sector_page_cache_control;
    import lspc_pkg::*;

    localparam int NPAGE  = PAGE_COUNT_DEF;
    localparam int PSHIFT = PAGE_SHIFT_DEF;
    localparam int PSECT  = 1 << PSHIFT;
    localparam int MAXREQ = MAX_REQUEST_SECTORS_DEF;
    localparam int NONE   = NPAGE;
    localparam longint unsigned CYCLE_LIMIT = 2000000;

    typedef struct packed {
        cmd_t        cmd;
        logic [4:0]  slot;
        logic [1:0]  poff;
        logic [31:0] dsec;
        logic [6:0]  cnt;
        logic [5:0]  boff;
        logic        last;
    } mover_cmd_t;

    typedef struct {
        action_t     act;
        logic [3:0]  drive;
        logic [31:0] sec;
        logic [6:0]  num;
        logic        aligned;
        logic        has_exp;   // row carries a hand-typed single result
        cmd_t        exp_cmd;
    } req_row_t;

    logic        aclk = 0;
    logic        aresetn = 0;
    logic        s_tvalid = 0;
    logic        s_tready;
    logic [47:0] s_tdata = '0;
    logic [1:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 0;
    logic [55:0] m_tdata;
    logic [2:0]  m_tuser;
    logic        m_tlast;
    logic        cfg_valid = 0;
    logic        cfg_ready;
    logic        cfg_data = 0;

    lru_sector_page_cache_control DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .m_tlast(m_tlast),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    initial begin
        forever #10 aclk = ~aclk;
    end

    // Shadow of the tag store and recency list.
    logic [29:0] tag_q [NPAGE];
    logic        vld_q [NPAGE];
    int          newer_q [NPAGE];
    int          older_q [NPAGE];
    int          newest_q, oldest_q;
    logic [3:0]  owner_q;
    logic        ready_q;
    logic        enable_q;

    mover_cmd_t  pending_cmds[$];
    int          errors = 0;
    int          hold_off = 0;     // long receiver stall, counted down by the sink
    longint unsigned cyc = 0;

    function automatic void clear_pages();
        for (int i = 0; i < NPAGE; i++) begin
            tag_q[i] = '0;
            vld_q[i] = 0;
            newer_q[i] = (i != 0) ? i - 1 : NONE;
            older_q[i] = (i + 1 < NPAGE) ? i + 1 : NONE;
        end
        newest_q = 0;
        oldest_q = NPAGE - 1;
        ready_q = 1;
    endfunction

    function automatic void push_cmd(cmd_t c, int s, int po, longint unsigned ds, int n,
                                     int bo, bit l);
        mover_cmd_t e;
        e.cmd = c; e.slot = s[4:0]; e.poff = po[1:0]; e.dsec = ds[31:0];
        e.cnt = n[6:0]; e.boff = bo[5:0]; e.last = l;
        pending_cmds.push_back(e);
    endfunction

    // Hit slot, else the valid slot holding the smallest tag above, else none.
    function automatic int lookup_page(logic [29:0] tg);
        int p, best;
        p = newest_q;
        best = NONE;
        for (int k = 0; k < NPAGE && p < NPAGE; k++) begin
            if (!vld_q[p]) break;
            if (tag_q[p] == tg) return p;
            if (tag_q[p] > tg && (best == NONE || tag_q[p] < tag_q[best])) best = p;
            p = older_q[p];
        end
        return best;
    endfunction

    function automatic void make_newest(int p);
        int nw, od;
        if (p >= NPAGE || p == newest_q) return;
        nw = newer_q[p];
        od = older_q[p];
        if (nw < NPAGE) older_q[nw] = od;
        if (od < NPAGE) newer_q[od] = nw;
        else oldest_q = nw;
        older_q[p] = newest_q;
        if (newest_q < NPAGE) newer_q[newest_q] = p;
        newer_q[p] = NONE;
        newest_q = p;
    endfunction

    // Oldest slot, stepping toward empty slots while the next newer one is empty too.
    function automatic int victim_slot();
        int p, nw;
        p = oldest_q;
        for (int k = 0; k < NPAGE; k++) begin
            nw = newer_q[p];
            if (vld_q[p] || nw >= NPAGE || vld_q[nw]) break;
            p = nw;
        end
        return p;
    endfunction

    function automatic void split_cached(longint unsigned sec, int num, bit wr, bit al);
        bit partial;
        int p, boff, poff, cur;
        longint unsigned sbase, pbase, lim;
        logic [29:0] tg;
        partial = num < PSECT;
        p = NONE; boff = 0; sbase = 0;
        for (int g = 0; num != 0 && g < 4 * MAXREQ + 8; g++) begin
            pbase = sec & ~longint'(PSECT - 1);
            poff = int'(sec & (PSECT - 1));
            tg = 30'(pbase >> PSHIFT);
            cur = PSECT - poff;
            if (num < cur) cur = num;
            if (pbase >= sbase) begin
                p = lookup_page(tg);
                sbase = (p < NPAGE) ? ((longint'(tag_q[p]) << PSHIFT) + 1) : '1;
            end
            if (p < NPAGE && tag_q[p] == tg) begin
                push_cmd(wr ? CMD_WTHRU : CMD_COPY, p, poff, sec, cur, boff, 0);
                if (!(poff == 0 && cur == PSECT)) make_newest(p);
            end else if (!wr && (partial || !al)) begin
                p = victim_slot();
                tag_q[p] = tg;
                vld_q[p] = 1;
                push_cmd(CMD_FILL, p, 0, pbase, PSECT, 0, 0);
                make_newest(p);
                sbase = pbase + 1;
                continue;
            end else begin
                lim = (p < NPAGE) ? ((longint'(tag_q[p]) << PSHIFT) - sec) : num;
                cur = (lim < num) ? int'(lim) : num;
                push_cmd(wr ? CMD_DWRITE : CMD_DREAD, 0, 0, sec, cur, boff, 0);
            end
            boff += cur;
            sec += cur;
            num -= cur;
        end
    endfunction

    function automatic void predict_request(req_row_t r);
        bit wr;
        wr = r.act == ACT_WRITE;
        if (r.act == ACT_BAD) begin
            push_cmd(CMD_REJECT, 0, 0, 0, 0, 0, 1);
        end else if (r.act == ACT_INVAL) begin
            clear_pages();
            push_cmd(CMD_DONE, 0, 0, 0, 0, 0, 1);
        end else if (r.num == 0) begin
            push_cmd(CMD_DONE, 0, 0, 0, 0, 0, 1);
        end else if (r.num > MAXREQ || longint'(r.sec) + r.num > 64'h1_0000_0000) begin
            push_cmd(CMD_REJECT, 0, 0, 0, 0, 0, 1);
        end else if (!enable_q) begin
            push_cmd(wr ? CMD_DWRITE : CMD_DREAD, 0, 0, r.sec, r.num, 0, 0);
            push_cmd(CMD_DONE, 0, 0, 0, 0, 0, 1);
        end else begin
            if (!ready_q || r.drive != owner_q) begin
                clear_pages();
                owner_q = r.drive;
            end
            split_cached(r.sec, r.num, wr, r.aligned);
            push_cmd(CMD_DONE, 0, 0, 0, 0, 0, 1);
        end
    endfunction

    function automatic int short_or_long_gap();
        return ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 2);
    endfunction

    // Send one request beat; the prediction is made when the beat is accepted.
    // Valid stays high into the next call when no gap follows.
    task automatic send_request(req_row_t r);
        int gap;
        gap = ($urandom_range(0, 3) == 0) ? 0 : short_or_long_gap();
        if (gap > 0) begin
            s_tvalid <= 0;
            repeat (gap) @(posedge aclk);
        end
        s_tdata <= {4'b0, r.aligned, r.num, r.sec, r.drive};
        s_tuser <= r.act;
        s_tvalid <= 1;
        do @(posedge aclk); while (!s_tready);
        if (r.has_exp) begin
            // Hand-typed single result; the predictor still tracks the state.
            predict_request(r);
            if (pending_cmds[$].cmd != r.exp_cmd) begin
                $display("%0t table row: expected cmd %0d, predictor %0d", $time,
                         r.exp_cmd, pending_cmds[$].cmd);
                errors++;
            end
        end else begin
            predict_request(r);
        end
    endtask

    task automatic drain_all();
        s_tvalid <= 0;
        while (pending_cmds.size() != 0) @(posedge aclk);
        // Leave room for a request still being worked through.
        repeat (400) @(posedge aclk);
    endtask

    task automatic write_enable(logic v);
        cfg_data <= v;
        cfg_valid <= 1;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 0;
        enable_q = v;
        ready_q = 0;
    endtask

    function automatic req_row_t mk(action_t a, int d, logic [31:0] s, int n, bit al,
                                    bit he = 0, cmd_t ec = CMD_DONE);
        req_row_t r;
        r.act = a; r.drive = d[3:0]; r.sec = s; r.num = n[6:0]; r.aligned = al;
        r.has_exp = he; r.exp_cmd = ec;
        return r;
    endfunction

    // Mostly requests that revisit a small sector window so pages hit and evict.
    function automatic req_row_t random_request(logic [3:0] drv);
        req_row_t r;
        int k;
        k = $urandom_range(0, 99);
        r = mk(action_t'($urandom_range(0, 1)), drv, $urandom_range(0, 400),
               $urandom_range(1, 20), 1'($urandom_range(0, 1)));
        if (k < 4) r.act = ACT_INVAL;
        else if (k < 6) r.act = ACT_BAD;
        else if (k < 9) r.drive = 4'($urandom_range(0, 15));
        else if (k < 12) r.num = 7'($urandom_range(0, 127));
        else if (k < 15) r.sec = $urandom();
        else if (k < 18) r.sec = 32'hFFFF_FFFF - 32'($urandom_range(0, 70));
        else if (k < 22) r.num = 7'($urandom_range(40, 64));
        return r;
    endfunction

    // Result side: random stalls, one long hold-off while requests keep coming.
    initial begin
        int gap;
        mover_cmd_t got, want;
        forever begin
            @(posedge aclk);
            if (hold_off > 0) begin
                hold_off--;
                m_tready <= 0;
            end else begin
                gap = ($urandom_range(0, 2) == 0) ? short_or_long_gap() : 0;
                m_tready <= (gap == 0);
            end
            if (m_tvalid && m_tready) begin
                got.cmd = cmd_t'(m_tuser);
                {got.boff, got.cnt, got.dsec, got.poff, got.slot} = m_tdata[51:0];
                got.last = m_tlast;
                if (pending_cmds.size() == 0) begin
                    $display("%0t unexpected beat: actual %h", $time, got);
                    errors++;
                end else begin
                    want = pending_cmds.pop_front();
                    if (got !== want) begin
                        $display("%0t mismatch: expected cmd=%0d slot=%0d poff=%0d sec=%h cnt=%0d boff=%0d last=%0b",
                                 $time, want.cmd, want.slot, want.poff, want.dsec, want.cnt,
                                 want.boff, want.last);
                        $display("%0t          actual cmd=%0d slot=%0d poff=%0d sec=%h cnt=%0d boff=%0d last=%0b",
                                 $time, got.cmd, got.slot, got.poff, got.dsec, got.cnt,
                                 got.boff, got.last);
                        errors++;
                    end
                end
            end
        end
    end

    // Watchdog on total cycles.
    initial begin
        forever begin
            @(posedge aclk);
            cyc++;
            if (cyc > CYCLE_LIMIT) begin
                $display("simulation failed");
                $finish;
            end
        end
    end

    req_row_t dir_rows[$];

    initial begin
        logic [3:0] drv;
        enable_q = 1;
        ready_q = 0;
        owner_q = 0;
        clear_pages();
        ready_q = 0;
        repeat (4) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        // Directed rows: open cases with a typed result, then cache behavior.
        dir_rows.push_back(mk(ACT_BAD,   0, 0, 4, 1, 1, CMD_REJECT));
        dir_rows.push_back(mk(ACT_READ,  0, 0, 0, 1, 1, CMD_DONE));
        dir_rows.push_back(mk(ACT_READ,  0, 0, 65, 1, 1, CMD_REJECT));
        dir_rows.push_back(mk(ACT_READ,  0, 0, 127, 0, 1, CMD_REJECT));
        dir_rows.push_back(mk(ACT_WRITE, 0, 32'hFFFF_FFFE, 3, 1, 1, CMD_REJECT));
        dir_rows.push_back(mk(ACT_INVAL, 15, 0, 0, 0, 1, CMD_DONE));
        dir_rows.push_back(mk(ACT_READ,  0, 32'hFFFF_FFFF, 1, 0));
        dir_rows.push_back(mk(ACT_READ,  0, 32'hFFFF_FFC0, 64, 1));
        dir_rows.push_back(mk(ACT_READ,  0, 5, 2, 1));      // partial read fills
        dir_rows.push_back(mk(ACT_READ,  0, 4, 4, 1));      // whole-page hit
        dir_rows.push_back(mk(ACT_READ,  0, 0, 16, 1));     // direct around a page
        dir_rows.push_back(mk(ACT_READ,  0, 1, 14, 0));     // unaligned fills
        dir_rows.push_back(mk(ACT_WRITE, 0, 2, 12, 1));     // write-through hits
        dir_rows.push_back(mk(ACT_WRITE, 0, 100, 64, 0));   // direct write
        dir_rows.push_back(mk(ACT_READ,  9, 6, 3, 1));      // drive change clears
        dir_rows.push_back(mk(ACT_READ,  9, 0, 64, 0));     // fills many pages
        dir_rows.push_back(mk(ACT_READ,  9, 256, 64, 0));   // fills the cache to capacity
        dir_rows.push_back(mk(ACT_INVAL, 9, 0, 0, 0, 1, CMD_DONE));
        dir_rows.push_back(mk(ACT_READ,  9, 8, 1, 1));
        foreach (dir_rows[i]) send_request(dir_rows[i]);
        drain_all();

        // Phases over the enable setting: off, on, off, on.
        for (int ph = 0; ph < 4; ph++) begin
            write_enable(ph[0]);
            drv = 4'($urandom_range(0, 15));
            for (int i = 0; i < 25; i++) begin
                if (ph == 1 && i == 10) hold_off = 300;
                send_request(random_request(drv));
            end
            drain_all();
        end

        if (errors == 0 && pending_cmds.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
